>>> src/tile_lru_cache_with_writeback_macros.svh
// Assertion macros used by the checker file of the tile cache.
`ifndef TILE_LRU_CACHE_WITH_WRITEBACK_MACROS_SVH
`define TILE_LRU_CACHE_WITH_WRITEBACK_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define TLC_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("tile cache check failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define TLC_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("tile cache check failed");

`endif

>>> src/tlc_pkg.sv
package tlc_pkg;

  localparam int CAPACITY = 32;
  localparam int SLOT_W   = 5;
  localparam int OCC_W    = 6;

  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_MARK   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] KIND_HIT     = 3'd0;
  localparam logic [2:0] KIND_MISS    = 3'd1;
  localparam logic [2:0] KIND_WB      = 3'd2;
  localparam logic [2:0] KIND_DROP    = 3'd3;
  localparam logic [2:0] KIND_PIN     = 3'd4;
  localparam logic [2:0] KIND_MARKED  = 3'd5;
  localparam logic [2:0] KIND_CLEARED = 3'd6;

  localparam logic [1:0] CFG_LIMIT = 2'd0;
  localparam logic [1:0] CFG_KEEP  = 2'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  style_id;
    logic [4:0]  tile_zoom;
    logic [30:0] tile_x;
    logic [30:0] tile_y;
    logic        stored_copy_present;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [4:0]  slot_index;
    logic        load_request;
    logic [7:0]  subject_style;
    logic [4:0]  subject_zoom;
    logic [30:0] subject_x;
    logic [30:0] subject_y;
    logic        last_result;
  } res_t;

  typedef struct packed {
    logic [7:0]  style;
    logic [4:0]  zoom;
    logic [30:0] col;
    logic [30:0] row;
  } key_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISP, ST_SCAN, ST_HIT, ST_MARK, ST_CLEAR,
    ST_FSEL, ST_FRD, ST_FEV, ST_INSERT,
    ST_ECHK, ST_ESEL, ST_ERD, ST_EACT
  } state_t;

  typedef struct packed {
    logic take;
    logic scan_start;
    logic do_hit;
    logic do_mark;
    logic do_clear;
    logic vsel;
    logic do_full_evict;
    logic do_insert;
    logic do_evict;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       scan_done;
    logic       hit;
    logic       full;
    logic       over;
    logic       pin;
    logic       out_free;
  } stat_t;

endpackage

>>> src/tlc_ctrl.sv
module tlc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tlc_pkg::stat_t stat,
  output tlc_pkg::cmd_t  cmd
);
  import tlc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DISP;
      ST_DISP:   state_nxt = (stat.opcode == OP_NONE) ? ST_IDLE : ST_SCAN;
      ST_SCAN: begin
        if (stat.scan_done) begin
          case (stat.opcode)
            OP_ACCESS: state_nxt = stat.hit ? ST_HIT : (stat.full ? ST_FSEL : ST_INSERT);
            OP_MARK:   state_nxt = stat.hit ? ST_MARK : ST_IDLE;
            default:   state_nxt = ST_CLEAR;
          endcase
        end
      end
      ST_HIT:    if (stat.out_free) state_nxt = ST_ECHK;
      ST_MARK:   if (stat.out_free) state_nxt = ST_IDLE;
      ST_CLEAR:  if (stat.out_free) state_nxt = ST_IDLE;
      ST_FSEL:   state_nxt = ST_FRD;
      ST_FRD:    state_nxt = ST_FEV;
      ST_FEV:    if (stat.out_free) state_nxt = ST_INSERT;
      ST_INSERT: if (stat.out_free) state_nxt = ST_ECHK;
      ST_ECHK:   state_nxt = stat.over ? ST_ESEL : ST_IDLE;
      ST_ESEL:   state_nxt = ST_ERD;
      ST_ERD:    state_nxt = ST_EACT;
      ST_EACT:   if (stat.out_free) state_nxt = stat.pin ? ST_IDLE : ST_ECHK;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:   cmd.take          = in_valid;
      ST_DISP:   cmd.scan_start    = (stat.opcode != OP_NONE);
      ST_HIT:    cmd.do_hit        = stat.out_free;
      ST_MARK:   cmd.do_mark       = stat.out_free;
      ST_CLEAR:  cmd.do_clear      = stat.out_free;
      ST_FSEL:   cmd.vsel          = 1'b1;
      ST_FEV:    cmd.do_full_evict = stat.out_free;
      ST_INSERT: cmd.do_insert     = stat.out_free;
      ST_ESEL:   cmd.vsel          = 1'b1;
      ST_EACT:   cmd.do_evict      = stat.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

>>> src/tlc_datapath.sv
module tlc_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  tlc_pkg::req_t  in_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [5:0]     cfg_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tlc_pkg::res_t  out_data,
  input  tlc_pkg::cmd_t  cmd,
  output tlc_pkg::stat_t stat
);
  import tlc_pkg::*;

  // Configuration.
  logic [OCC_W-1:0] cap_r;
  logic [4:0]       keep_r;
  logic [OCC_W-1:0] lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= OCC_W'(CAPACITY);
      keep_r <= 5'd12;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LIMIT) cap_r <= cfg_data;
      if (cfg_index == CFG_KEEP)  keep_r <= cfg_data[4:0];
    end
  end

  always_comb begin
    lim = cap_r;
    if (cap_r == '0) lim = OCC_W'(1);
    if (cap_r > OCC_W'(CAPACITY)) lim = OCC_W'(CAPACITY);
  end

  // Request register.
  req_t req_r;
  key_t req_key;
  always_ff @(posedge clk) begin
    if (cmd.take) req_r <= in_data;
  end
  assign req_key = '{style: req_r.style_id, zoom: req_r.tile_zoom,
                     col: req_r.tile_x, row: req_r.tile_y};

  // Key memory, one read port with registered data.
  key_t key_mem [CAPACITY];
  key_t rd_key_r;
  logic [SLOT_W-1:0] rd_addr, rd_slot_r;
  logic rd_vld_r;
  logic scan_on_r;
  logic [SLOT_W-1:0] scan_cnt_r;
  logic [SLOT_W-1:0] victim_r, free_slot;
  logic mem_we;

  assign rd_addr = scan_on_r ? scan_cnt_r : victim_r;
  assign mem_we  = cmd.do_insert;

  always_ff @(posedge clk) begin
    if (mem_we) key_mem[free_slot] <= req_key;
    rd_key_r  <= key_mem[rd_addr];
    rd_slot_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_on_r  <= 1'b0;
      scan_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= scan_on_r;
      if (cmd.scan_start) begin
        scan_on_r  <= 1'b1;
        scan_cnt_r <= '0;
      end else if (scan_on_r) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
        if (scan_cnt_r == SLOT_W'(CAPACITY - 1)) scan_on_r <= 1'b0;
      end
    end
  end

  // Per-slot state in flip-flops.
  logic [CAPACITY-1:0] valid_r, valid_nxt, rend_r, rend_nxt;
  logic [SLOT_W-1:0]   rank_r [CAPACITY];
  logic [SLOT_W-1:0]   rank_nxt [CAPACITY];
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic                hit_r;
  logic [SLOT_W-1:0]   hit_slot_r;

  logic clear_mode, cmp_valid, key_match, style_match;
  logic keepable, pin;
  logic do_remove, do_front;
  logic [SLOT_W-1:0] rm_slot, fr_slot;

  assign clear_mode  = (req_r.opcode == OP_CLEAR);
  assign cmp_valid   = rd_vld_r && valid_r[rd_slot_r];
  assign key_match   = cmp_valid && !clear_mode && (rd_key_r == req_key);
  assign style_match = cmp_valid && clear_mode && (rd_key_r.style == req_r.style_id);
  assign keepable    = (rd_key_r.zoom <= keep_r);
  assign pin         = keepable && !rend_r[victim_r];

  assign do_remove = style_match || cmd.do_full_evict || (cmd.do_evict && !pin);
  assign rm_slot   = style_match ? rd_slot_r : victim_r;
  assign do_front  = cmd.do_hit || (cmd.do_evict && pin);
  assign fr_slot   = cmd.do_hit ? hit_slot_r : victim_r;

  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_slot = SLOT_W'(i);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    rend_nxt  = rend_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < CAPACITY; i++) rank_nxt[i] = rank_r[i];
    if (do_remove) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (valid_r[i] && SLOT_W'(i) != rm_slot && rank_r[i] > rank_r[rm_slot])
          rank_nxt[i] = rank_r[i] - 1'b1;
      end
      valid_nxt[rm_slot] = 1'b0;
      rend_nxt[rm_slot]  = 1'b0;
      occ_nxt            = occ_r - 1'b1;
    end else if (do_front) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (valid_r[i] && SLOT_W'(i) != fr_slot && rank_r[i] < rank_r[fr_slot])
          rank_nxt[i] = rank_r[i] + 1'b1;
      end
      rank_nxt[fr_slot] = '0;
    end else if (cmd.do_insert) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (valid_r[i]) rank_nxt[i] = rank_r[i] + 1'b1;
      end
      valid_nxt[free_slot] = 1'b1;
      rend_nxt[free_slot]  = (req_r.tile_zoom <= keep_r) && req_r.stored_copy_present;
      rank_nxt[free_slot]  = '0;
      occ_nxt              = occ_r + 1'b1;
    end else if (cmd.do_mark) begin
      rend_nxt[hit_slot_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rend_r  <= '0;
      occ_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      rend_r  <= rend_nxt;
      occ_r   <= occ_nxt;
    end
    for (int i = 0; i < CAPACITY; i++) rank_r[i] <= rank_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.scan_start) begin
      hit_r <= 1'b0;
    end else if (key_match) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (key_match) hit_slot_r <= rd_slot_r;
  end

  // The least recently used entry holds rank occupancy minus one.
  logic [SLOT_W-1:0] lru_slot, lru_rank;
  assign lru_rank = SLOT_W'(occ_r - 1'b1);
  always_comb begin
    lru_slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (valid_r[i] && rank_r[i] == lru_rank) lru_slot = SLOT_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vsel) victim_r <= lru_slot;
  end

  // Output register.
  logic out_valid_r;
  res_t out_r, res;
  logic emit;

  assign emit = cmd.do_hit || cmd.do_mark || cmd.do_clear || cmd.do_full_evict ||
                cmd.do_insert || cmd.do_evict;

  always_comb begin
    res = '{result_kind: KIND_HIT, slot_index: hit_slot_r, load_request: 1'b0,
            subject_style: req_r.style_id, subject_zoom: req_r.tile_zoom,
            subject_x: req_r.tile_x, subject_y: req_r.tile_y,
            last_result: !(occ_r > lim)};
    if (cmd.do_mark) begin
      res.result_kind = KIND_MARKED;
      res.last_result = 1'b1;
    end else if (cmd.do_clear) begin
      res = '0;
      res.result_kind   = KIND_CLEARED;
      res.subject_style = req_r.style_id;
      res.last_result   = 1'b1;
    end else if (cmd.do_insert) begin
      res.result_kind  = KIND_MISS;
      res.slot_index   = free_slot;
      res.load_request = (req_r.tile_zoom <= keep_r);
      res.last_result  = ((occ_r + 1'b1) <= lim);
    end else if (cmd.do_full_evict || cmd.do_evict) begin
      res.slot_index    = victim_r;
      res.subject_style = rd_key_r.style;
      res.subject_zoom  = rd_key_r.zoom;
      res.subject_x     = rd_key_r.col;
      res.subject_y     = rd_key_r.row;
      if (keepable && rend_r[victim_r]) res.result_kind = KIND_WB;
      else if (cmd.do_evict && pin)     res.result_kind = KIND_PIN;
      else                              res.result_kind = KIND_DROP;
      if (cmd.do_full_evict) res.last_result = 1'b0;
      else res.last_result = pin || ((occ_r - 1'b1) <= lim);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat.opcode    = req_r.opcode;
  assign stat.scan_done = rd_vld_r && (rd_slot_r == SLOT_W'(CAPACITY - 1));
  assign stat.hit       = hit_r || key_match;
  assign stat.full      = (occ_r >= OCC_W'(CAPACITY));
  assign stat.over      = (occ_r > lim);
  assign stat.pin       = pin;
  assign stat.out_free  = !out_valid_r || !out_stall;

endmodule

>>> src/tile_lru_cache_with_writeback.sv
// Channel   Direction  Handshake          Payload
// in_       request    in_valid/in_stall  tlc_pkg::req_t in_data
// out_      result     out_valid/out_stall tlc_pkg::res_t out_data
// cfg_      write      cfg_we             cfg_index, cfg_data
//
// Every request but the unused opcode runs a tag scan over the key memory, one
// slot per cycle, and a new request is taken only once the previous one is done.
// Each trim eviction steps through ECHK, ESEL, ERD and EACT, the eviction before
// a miss on a full table through FSEL, FRD and FEV; unused opcodes give no result.
// Reset (rst_n low, synchronous) empties the table and restores the registers.
// A stalled result holds the sequencer in its emit state until it is taken.
module tile_lru_cache_with_writeback (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tlc_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tlc_pkg::res_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [5:0]    cfg_data
);
  import tlc_pkg::*;

  // The controller sequences every request: it latches it, starts the tag scan
  // (not for the unused opcode), then walks the hit, mark, clear, insert and
  // eviction steps. Each step that emits a result waits for a free output register.
  cmd_t  cmd;
  stat_t stat;

  tlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the key memory, the recency ranks, the valid and
  // rendered flags, the configuration registers and the result register.
  tlc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> src/tlc_checker.sv
`include "tile_lru_cache_with_writeback_macros.svh"

module tlc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input tlc_pkg::req_t in_data,
  input logic          out_valid,
  input logic          out_stall,
  input tlc_pkg::res_t out_data
);
  import tlc_pkg::*;

  `TLC_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
  `TLC_ASSERT_NEXT(a_idle_no_new_result, clk, rst_n, !in_stall && !out_valid, !out_valid)
  `TLC_ASSERT_IMPLY(a_kind_legal, clk, rst_n, out_valid, out_data.result_kind <= KIND_CLEARED)
  `TLC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

endmodule

bind tile_lru_cache_with_writeback tlc_checker u_chk (.*);

>>> tb/tb_tile_lru_cache_with_writeback.sv
// Self-checking bench for the tile cache. A behavioral copy of the tag store
// runs alongside the RTL, and it predicts every result of each accepted
// request. Results are compared field by field in arrival order.
module tb_tile_lru_cache_with_writeback;
  import tlc_pkg::*;

  localparam int SETTLE_CYCLES = 200;

  // One row of the directed stimulus. A row is either a register write or a
  // request. A request may carry a typed result that replaces the predicted one.
  typedef struct {
    bit         is_cfg;
    logic [1:0] cfg_idx;
    logic [5:0] cfg_val;
    req_t       req;
    bit         has_res;
    res_t       res;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  res_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [5:0] cfg_data;

  tile_lru_cache_with_writeback u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the tag store and the two registers.
  logic [5:0]  shadow_limit;
  logic [4:0]  shadow_keep;
  bit          slot_valid [CAPACITY];
  bit          slot_rendered [CAPACITY];
  key_t        slot_key [CAPACITY];
  int unsigned slot_rank [CAPACITY];
  int unsigned slot_count;

  res_t pending_results [$];
  int   error_count;
  int   send_gap_pct;
  int   stall_pct;
  bit   stall_quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #8000000;
    $display("tile_lru_cache_with_writeback verification failed");
    $finish;
  end

  function automatic void push_slot(logic [2:0] kind, int s);
    res_t r;
    r = '0;
    r.result_kind   = kind;
    r.slot_index    = s[4:0];
    r.subject_style = slot_key[s].style;
    r.subject_zoom  = slot_key[s].zoom;
    r.subject_x     = slot_key[s].col;
    r.subject_y     = slot_key[s].row;
    pending_results.push_back(r);
  endfunction

  function automatic void make_mru(int s);
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  function automatic void drop_slot(int s);
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_valid[i] && i != s && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
    end
    slot_valid[s] = 1'b0;
    slot_rendered[s] = 1'b0;
    if (slot_count > 0) slot_count--;
  endfunction

  // Oldest valid entry; on equal ranks the highest slot wins.
  function automatic int oldest_slot();
    int best;
    int unsigned br;
    bit any;
    best = 0;
    br = 0;
    any = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_valid[i] && (!any || slot_rank[i] >= br)) begin
        best = i;
        br = slot_rank[i];
        any = 1'b1;
      end
    end
    return best;
  endfunction

  function automatic bit is_keepable(int s);
    return slot_key[s].zoom <= shadow_keep;
  endfunction

  // Works out every result that one request causes, in order.
  function automatic void predict_request(req_t q);
    key_t k;
    int found;
    int s;
    int v;
    int unsigned lim;
    int start;
    bit load;
    res_t r;
    k = '{style: q.style_id, zoom: q.tile_zoom, col: q.tile_x, row: q.tile_y};
    start = pending_results.size();
    lim = shadow_limit;
    if (lim < 1) lim = 1;
    if (lim > CAPACITY) lim = CAPACITY;
    found = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (found < 0 && slot_valid[i] && slot_key[i] == k) found = i;
    end
    case (q.opcode)
      OP_MARK: begin
        if (found >= 0) begin
          slot_rendered[found] = 1'b1;
          push_slot(KIND_MARKED, found);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (slot_valid[i] && slot_key[i].style == q.style_id) drop_slot(i);
        end
        r = '0;
        r.result_kind = KIND_CLEARED;
        r.subject_style = q.style_id;
        pending_results.push_back(r);
      end
      OP_ACCESS: begin
        if (found >= 0) begin
          make_mru(found);
          push_slot(KIND_HIT, found);
        end else begin
          load = q.tile_zoom <= shadow_keep;
          // A full table gives up its oldest entry before the miss is reported.
          if (slot_count >= CAPACITY) begin
            v = oldest_slot();
            push_slot((is_keepable(v) && slot_rendered[v]) ? KIND_WB : KIND_DROP, v);
            drop_slot(v);
          end
          s = 0;
          while (s < CAPACITY && slot_valid[s]) s++;
          if (s >= CAPACITY) s = 0;
          for (int i = 0; i < CAPACITY; i++) begin
            if (slot_valid[i]) slot_rank[i]++;
          end
          slot_valid[s] = 1'b1;
          slot_rendered[s] = load && q.stored_copy_present;
          slot_key[s] = k;
          slot_rank[s] = 0;
          slot_count++;
          push_slot(KIND_MISS, s);
          pending_results[$].load_request = load;
        end
        // Trim down to the limit; an unrendered keepable victim stops the trim.
        while (slot_count > lim) begin
          v = oldest_slot();
          if (is_keepable(v) && !slot_rendered[v]) begin
            make_mru(v);
            push_slot(KIND_PIN, v);
            break;
          end
          push_slot(is_keepable(v) ? KIND_WB : KIND_DROP, v);
          drop_slot(v);
        end
      end
      default: ;
    endcase
    if (pending_results.size() > start) pending_results[$].last_result = 1'b1;
  endfunction

  // Register writes wait until the block has gone quiet: every result is in,
  // and enough cycles have passed for a request that yields nothing to leave.
  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == CFG_LIMIT) shadow_limit = val;
    else if (idx == CFG_KEEP) shadow_keep = val[4:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offers one request, holds it until accepted, then runs the prediction.
  // A typed result, when given, stands in for the first predicted one.
  task automatic send_request(req_t q, bit has_res, res_t typed);
    int start;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = q;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    start = pending_results.size();
    predict_request(q);
    if (has_res && pending_results.size() > start) pending_results[start] = typed;
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic res_t typed_res(logic [2:0] kind, int slot, bit load, key_t k);
    res_t r;
    r = '0;
    r.result_kind = kind;
    r.slot_index = slot[4:0];
    r.load_request = load;
    r.subject_style = k.style;
    r.subject_zoom = k.zoom;
    r.subject_x = k.col;
    r.subject_y = k.row;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic req_t make_req(logic [1:0] op, key_t k, bit present);
    req_t q;
    q.opcode = op;
    q.style_id = k.style;
    q.tile_zoom = k.zoom;
    q.tile_x = k.col;
    q.tile_y = k.row;
    q.stored_copy_present = present;
    return q;
  endfunction

  function automatic key_t random_key();
    key_t k;
    k.style = 8'($urandom_range(255));
    k.zoom = 5'($urandom_range(31));
    k.col = 31'($urandom() >> 1);
    k.row = 31'($urandom() >> 1);
    return k;
  endfunction

  // Receiver side: random stalls, with quiet stretches that come and go.
  always @(negedge clk) begin
    if ($urandom_range(47) == 0) stall_quiet <= ~stall_quiet;
    out_stall <= !stall_quiet && ($urandom_range(99) < stall_pct);
  end

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      error_count++;
    end
  endtask

  // Every result taken by the bench is held against the oldest expectation.
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: kind %0d slot %0d",
               out_data.result_kind, out_data.slot_index);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("result_kind", e.result_kind, out_data.result_kind);
        check_field("slot_index", e.slot_index, out_data.slot_index);
        check_field("load_request", e.load_request, out_data.load_request);
        check_field("subject_style", e.subject_style, out_data.subject_style);
        check_field("subject_zoom", e.subject_zoom, out_data.subject_zoom);
        check_field("subject_x", e.subject_x, out_data.subject_x);
        check_field("subject_y", e.subject_y, out_data.subject_y);
        check_field("last_result", e.last_result, out_data.last_result);
      end
    end
  end

  // Directed rows run with the reset register values until the first write.
  // Tile keys used below: the all-zero and all-ones keys, two tiles at zoom 12
  // and 13 beside the keep level of 12, and four for the limit-of-one sequence.
  row_t directed [$];
  key_t key_zero, key_ones, key_z12, key_z13, key_a, key_b, key_c, key_d;

  function automatic void add_req(req_t q, bit has_res, res_t r);
    row_t w;
    w = '{is_cfg: 1'b0, cfg_idx: '0, cfg_val: '0, req: q, has_res: has_res, res: r};
    directed.push_back(w);
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [5:0] val);
    row_t w;
    w = '{is_cfg: 1'b1, cfg_idx: idx, cfg_val: val, req: '0, has_res: 1'b0, res: '0};
    directed.push_back(w);
  endfunction

  function automatic void build_directed();
    res_t r;
    key_zero = '0;
    key_ones = '1;
    key_z12 = '{style: 8'd1, zoom: 5'd12, col: 31'd5, row: 31'd6};
    key_z13 = '{style: 8'd1, zoom: 5'd13, col: 31'd5, row: 31'd6};
    key_a = '{style: 8'd7, zoom: 5'd5, col: 31'd100, row: 31'd200};
    key_b = '{style: 8'd7, zoom: 5'd20, col: 31'd101, row: 31'd201};
    key_c = '{style: 8'd8, zoom: 5'd3, col: 31'd102, row: 31'd202};
    key_d = '{style: 8'd8, zoom: 5'd4, col: 31'd103, row: 31'd203};
    // Empty table: first miss lands in slot 0 and asks for a load.
    add_req(make_req(OP_ACCESS, key_zero, 1'b1), 1'b1, typed_res(KIND_MISS, 0, 1'b1, key_zero));
    add_req(make_req(OP_ACCESS, key_zero, 1'b1), 1'b1, typed_res(KIND_HIT, 0, 1'b0, key_zero));
    // Above the keep level there is no load.
    add_req(make_req(OP_ACCESS, key_ones, 1'b1), 1'b1, typed_res(KIND_MISS, 1, 1'b0, key_ones));
    add_req(make_req(OP_MARK, key_ones, 1'b0), 1'b1, typed_res(KIND_MARKED, 1, 1'b0, key_ones));
    // Marking an absent tile and the unused opcode both yield nothing.
    add_req(make_req(OP_MARK, key_z12, 1'b0), 1'b0, r);
    add_req(make_req(OP_NONE, key_ones, 1'b1), 1'b0, r);
    r = '0;
    r.result_kind = KIND_CLEARED;
    r.subject_style = 8'hff;
    r.last_result = 1'b1;
    add_req(make_req(OP_CLEAR, key_ones, 1'b0), 1'b1, r);
    add_req(make_req(OP_ACCESS, key_z12, 1'b0), 1'b0, r);
    add_req(make_req(OP_ACCESS, key_z13, 1'b1), 1'b0, r);
    add_req(make_req(OP_CLEAR, key_z12, 1'b0), 1'b0, r);
    add_req(make_req(OP_CLEAR, key_zero, 1'b0), 1'b0, r);
    // Limit of one: write back, drop and the pinned unrendered case in turn.
    add_cfg(CFG_LIMIT, 6'd1);
    add_req(make_req(OP_ACCESS, key_a, 1'b1), 1'b0, r);
    add_req(make_req(OP_ACCESS, key_b, 1'b1), 1'b0, r);
    add_req(make_req(OP_ACCESS, key_c, 1'b0), 1'b0, r);
    add_req(make_req(OP_ACCESS, key_d, 1'b0), 1'b0, r);
    add_req(make_req(OP_MARK, key_c, 1'b0), 1'b0, r);
    add_req(make_req(OP_ACCESS, key_a, 1'b0), 1'b0, r);
    add_req(make_req(OP_CLEAR, key_c, 1'b0), 1'b0, r);
    add_req(make_req(OP_CLEAR, key_a, 1'b0), 1'b0, r);
  endfunction

  // Random phase: mostly accesses over a small pool of tiles so that hits,
  // marks and style clears find entries; fresh tiles keep the table churning.
  task automatic run_random(int count, int fresh_pct);
    key_t pool [10];
    key_t k;
    int sent;
    int pick;
    logic [7:0] styles [3];
    for (int i = 0; i < 3; i++) styles[i] = 8'($urandom_range(255));
    for (int i = 0; i < 10; i++) begin
      pool[i] = random_key();
      pool[i].style = styles[i % 3];
    end
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < fresh_pct) k = random_key();
      else k = pool[$urandom_range(9)];
      pick = $urandom_range(99);
      if (pick < 68) send_request(make_req(OP_ACCESS, k, 1'($urandom_range(1))), 1'b0, '0);
      else if (pick < 86) send_request(make_req(OP_MARK, k, 1'($urandom_range(1))), 1'b0, '0);
      else if (pick < 94) send_request(make_req(OP_CLEAR, k, 1'($urandom_range(1))), 1'b0, '0);
      else begin
        send_request(make_req(OP_NONE, k, 1'($urandom_range(1))), 1'b0, '0);
        sent--;
      end
      sent++;
      if ($urandom_range(15) == 0) go_idle();
    end
    go_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_LIMIT;
    cfg_data = '0;
    error_count = 0;
    stall_quiet = 1'b0;
    shadow_limit = 6'd32;
    shadow_keep = 5'd12;
    slot_count = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_valid[i] = 1'b0;
      slot_rendered[i] = 1'b0;
      slot_rank[i] = 0;
      slot_key[i] = '0;
    end
    build_directed();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // First phase: the sender rarely pauses and the receiver stalls often.
    send_gap_pct = 6;
    stall_pct = 52;
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        go_idle();
        write_reg(directed[i].cfg_idx, directed[i].cfg_val);
      end else begin
        send_request(directed[i].req, directed[i].has_res, directed[i].res);
      end
    end
    go_idle();
    write_reg(CFG_LIMIT, 6'd4);
    write_reg(CFG_KEEP, 6'd31);
    run_random(15, 30);
    write_reg(CFG_LIMIT, 6'd0);
    run_random(10, 30);

    // Second phase: the roles swap; keep level 0 makes nearly all tiles droppable.
    send_gap_pct = 52;
    stall_pct = 6;
    write_reg(CFG_LIMIT, 6'd6);
    write_reg(CFG_KEEP, 6'd0);
    run_random(30, 40);

    // Last phase: no send gaps or stalls; a limit past the table size lets the
    // table fill, so misses on a full table evict before they are reported.
    send_gap_pct = 0;
    stall_pct = 0;
    write_reg(CFG_LIMIT, 6'd63);
    write_reg(CFG_KEEP, 6'd12);
    run_random(35, 85);

    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("tile_lru_cache_with_writeback verification clean");
    end else begin
      $display("tile_lru_cache_with_writeback verification failed");
    end
    $finish;
  end

endmodule

>>> tile_lru_cache_with_writeback.f
+incdir+src
src/tlc_pkg.sv
src/tlc_ctrl.sv
src/tlc_datapath.sv
src/tile_lru_cache_with_writeback.sv
src/tlc_checker.sv
tb/tb_tile_lru_cache_with_writeback.sv
